### rtl/core/stro_pkg.sv
`default_nettype none

package stro_pkg;

  // Field widths
  localparam int unsigned FREQ_W  = 23;
  localparam int unsigned AMP_W   = 15;
  localparam int unsigned SHARE_W = 17;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned OUT_W   = 17;

  // Level is Q2.31 with sign, 16 fraction bits below the Q1.15 output grid
  localparam int unsigned FINE_W  = 34;
  localparam int unsigned FRAC_X  = 16;

  // Divider quotient width and iteration count width
  localparam int unsigned QUO_W   = 32;
  localparam int unsigned IT_W    = 6;

  localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(65536);

  localparam logic signed [OUT_W+1:0] OUT_MAX = (OUT_W+2)'(65535);
  localparam logic signed [OUT_W+1:0] OUT_MIN = -(OUT_W+2)'(65536);

  typedef struct packed {
    logic load;        // capture input beat
    logic per_start;   // start period divide (or force max period)
    logic per_take;    // store saturated period
    logic dir;         // update direction flag
    logic cnt;         // compute segment count
    logic jump;        // count is zero: level jumps to +peak or -peak
    logic step_start;  // start step divide
    logic step_take;   // apply step to the level
    logic emit;        // load output register
  } stro_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic div_busy;
    logic count_zero;
    logic out_free;
  } stro_sts_t;

endpackage

`default_nettype wire

### rtl/core/stro_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Dividend is left aligned by the caller so that iters_i steps finish it.
module stro_div #(
  parameter int unsigned DVW = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [stro_pkg::QUO_W-1:0] dividend_i,
  input  wire logic [DVW-1:0]             divisor_i,
  input  wire logic [stro_pkg::IT_W-1:0]  iters_i,
  output logic                            busy_o,
  output logic [stro_pkg::QUO_W-1:0]      quo_o
);
  import stro_pkg::*;

  logic             busy_q;
  logic [IT_W-1:0]  cnt_q;
  logic [DVW-1:0]   rem_q, rem_d;
  logic [DVW-1:0]   dvs_q;
  logic [QUO_W-1:0] quo_q;
  logic [DVW:0]     shifted;
  logic [DVW:0]     diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[QUO_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign rem_d   = ge ? diff[DVW-1:0] : shifted[DVW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= iters_i != '0;
      cnt_q  <= iters_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - IT_W'(1);
      if (cnt_q == IT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### rtl/core/stro_dp.sv
`default_nettype none

module stro_dp #(
  parameter int unsigned SAMPLE_RATE_HZ = 48000,
  parameter int unsigned MAX_PERIOD     = 1048575
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire stro_pkg::stro_cmd_t               cmd_i,
  output stro_pkg::stro_sts_t                    sts_o,
  input  wire logic [stro_pkg::FREQ_W-1:0]       freq_q8_i,
  input  wire logic [stro_pkg::AMP_W-1:0]        peak_level_i,
  input  wire logic [stro_pkg::SHARE_W-1:0]      rise_share_i,
  input  wire logic signed [stro_pkg::OFS_W-1:0] dc_shift_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [stro_pkg::OUT_W-1:0]      wave_out_o
);
  import stro_pkg::*;

  localparam int unsigned PW  = $clog2(MAX_PERIOD + 1);
  localparam int unsigned DVW = (PW > FREQ_W) ? PW : FREQ_W;
  localparam int unsigned NUM = SAMPLE_RATE_HZ * 256;
  localparam int unsigned NW  = $clog2(NUM + 1);
  localparam logic [QUO_W-1:0] NUM_ALIGN = QUO_W'(NUM) << (QUO_W - NW);
  localparam logic [PW-1:0]    PER_MAX   = PW'(MAX_PERIOD);
  localparam int unsigned LVL_W = FINE_W - FRAC_X;

  logic [FREQ_W-1:0]       freq_q;
  logic [AMP_W-1:0]        amp_q;
  logic [SHARE_W-1:0]      share_q;
  logic signed [OFS_W-1:0] ofs_q;
  logic [PW-1:0]           period_q;
  logic [PW-1:0]           count_q;
  logic                    falling_q;
  logic signed [FINE_W-1:0] fine_q;
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_q;

  logic                    div_start;
  logic [QUO_W-1:0]        div_dividend;
  logic [DVW-1:0]          div_divisor;
  logic [IT_W-1:0]         div_iters;
  logic                    div_busy;
  logic [QUO_W-1:0]        div_quo;

  logic signed [FINE_W-1:0] amp31;
  logic [SHARE_W-1:0]      share_eff;
  logic [SHARE_W+PW-1:0]   prod;
  logic signed [LVL_W-1:0] lvl;
  logic signed [OUT_W+1:0] sum;
  logic signed [OUT_W-1:0] sat;

  assign div_start    = cmd_i.per_start && (freq_q != '0) || cmd_i.step_start;
  assign div_dividend = cmd_i.per_start ? NUM_ALIGN : {amp_q, 17'b0};
  assign div_divisor  = cmd_i.per_start ? DVW'(freq_q) : DVW'(count_q);
  assign div_iters    = cmd_i.per_start ? IT_W'(NW) : IT_W'(QUO_W);

  stro_div #(
    .DVW(DVW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .iters_i   (div_iters),
    .busy_o    (div_busy),
    .quo_o     (div_quo)
  );

  assign amp31     = $signed({3'b000, amp_q, 16'b0});
  assign share_eff = falling_q ? (SHARE_ONE - share_q) : share_q;
  assign prod      = (SHARE_W+PW)'(share_eff) * (SHARE_W+PW)'(period_q);

  // floor to the output grid, add offset, clamp
  assign lvl = LVL_W'(fine_q >>> FRAC_X);
  assign sum = (OUT_W+2)'(lvl) + (OUT_W+2)'(ofs_q);
  always_comb begin
    if (sum > OUT_MAX) begin
      sat = OUT_MAX[OUT_W-1:0];
    end else if (sum < OUT_MIN) begin
      sat = OUT_MIN[OUT_W-1:0];
    end else begin
      sat = sum[OUT_W-1:0];
    end
  end

  // Input capture and intermediate payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      freq_q  <= freq_q8_i;
      amp_q   <= peak_level_i;
      share_q <= (rise_share_i > SHARE_ONE) ? SHARE_ONE : rise_share_i;
      ofs_q   <= dc_shift_i;
    end
    if (cmd_i.per_start && freq_q == '0) begin
      period_q <= PER_MAX;
    end else if (cmd_i.per_take) begin
      period_q <= (div_quo > QUO_W'(MAX_PERIOD)) ? PER_MAX : div_quo[PW-1:0];
    end
    if (cmd_i.cnt) begin
      count_q <= prod[FRAC_X +: PW];
    end
    if (cmd_i.emit) begin
      out_q <= sat;
    end
  end

  // Oscillator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      falling_q <= 1'b0;
      fine_q    <= '0;
    end else begin
      if (cmd_i.dir) begin
        if (fine_q >= amp31) begin
          falling_q <= 1'b1;
        end else if (fine_q <= -amp31) begin
          falling_q <= 1'b0;
        end
      end
      if (cmd_i.jump) begin
        fine_q <= falling_q ? -amp31 : amp31;
      end else if (cmd_i.step_take) begin
        if (falling_q) begin
          fine_q <= fine_q - $signed(FINE_W'(div_quo));
        end else begin
          fine_q <= fine_q + $signed(FINE_W'(div_quo));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.freq_zero  = freq_q == '0;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.count_zero = count_q == '0;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign wave_out_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/stro_ctrl.sv
`default_nettype none

module stro_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire stro_pkg::stro_sts_t sts_i,
  output stro_pkg::stro_cmd_t      cmd_o
);
  import stro_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PER   = 3'd1;
  localparam logic [2:0] S_PWAIT = 3'd2;
  localparam logic [2:0] S_DIR   = 3'd3;
  localparam logic [2:0] S_CNT   = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_SWAIT = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PER;
        end
      end
      S_PER: begin
        cmd_o.per_start = 1'b1;
        state_d = sts_i.freq_zero ? S_DIR : S_PWAIT;
      end
      S_PWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.per_take = 1'b1;
          state_d        = S_DIR;
        end
      end
      S_DIR: begin
        cmd_o.dir = 1'b1;
        state_d   = S_CNT;
      end
      S_CNT: begin
        cmd_o.cnt = 1'b1;
        state_d   = S_STEP;
      end
      S_STEP: begin
        if (sts_i.count_zero) begin
          cmd_o.jump = 1'b1;
          state_d    = S_OUT;
        end else begin
          cmd_o.step_start = 1'b1;
          state_d          = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.step_take = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

`default_nettype wire

### rtl/core/slewed_triangle_oscillator_core.sv
// Slewed triangle oscillator: one output sample per input beat.
// Input channel (in_valid_i / in_stall_o) carries frequency (Q.8 Hz),
// amplitude (Q0.15), rising share (Q1.16) and DC offset (Q1.15) for one
// sample. Output channel (out_valid_o / out_stall_i) returns the sample.
// One beat is processed at a time; in_stall_o is high from the beat's
// acceptance until its result enters the output register.
// The two divides run on the shared bit-serial divider: the period
// divide yields NW quotient bits, where NW = clog2(SAMPLE_RATE_HZ*256+1)
// (24 at 48 kHz), and the level step divide yields 32. Zero frequency
// skips the period divide; a zero segment count skips the step divide.
// Reset clears the direction to rising, the level to zero and drops
// output valid. A stalled output holds its sample; the core can accept
// and work on the next beat meanwhile, and waits only to load its result.
`default_nettype none

module slewed_triangle_oscillator_core #(
  parameter int unsigned SAMPLE_RATE_HZ = 48000,
  parameter int unsigned MAX_PERIOD     = 1048575
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [stro_pkg::FREQ_W-1:0]       freq_q8_i,
  input  wire logic [stro_pkg::AMP_W-1:0]        peak_level_i,
  input  wire logic [stro_pkg::SHARE_W-1:0]      rise_share_i,
  input  wire logic signed [stro_pkg::OFS_W-1:0] dc_shift_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [stro_pkg::OUT_W-1:0]      wave_out_o
);
  import stro_pkg::*;

  stro_cmd_t cmd;
  stro_sts_t sts;

  // Sequencer: period divide, direction, count, step divide, output
  stro_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Holds the beat, the oscillator state, divider and output register
  stro_dp #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ),
    .MAX_PERIOD    (MAX_PERIOD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .freq_q8_i   (freq_q8_i),
    .peak_level_i(peak_level_i),
    .rise_share_i(rise_share_i),
    .dc_shift_i  (dc_shift_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .wave_out_o  (wave_out_o)
  );

endmodule

`default_nettype wire

### rtl/core/stro_check.sv
`default_nettype none

module stro_check (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [stro_pkg::FREQ_W-1:0]       freq_q8_i,
  input wire logic [stro_pkg::AMP_W-1:0]        peak_level_i,
  input wire logic [stro_pkg::SHARE_W-1:0]      rise_share_i,
  input wire logic signed [stro_pkg::OFS_W-1:0] dc_shift_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic signed [stro_pkg::OUT_W-1:0] wave_out_o
);

  // Core is busy right after it takes a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  // A new sample appears only as the core returns to idle
  a_emit_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("sample emitted while still busy");

  // Held output beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // Held output beat keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(wave_out_o))
    else $error("output sample changed under stall");

endmodule

bind slewed_triangle_oscillator_core stro_check u_stro_check (.*);

`default_nettype wire
